// ----- hdl/crczg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crczg_pkg - shared types, constants and the CRC byte update
// Reflected CRC-32 (poly 0xEDB88320) constants, register indexes, step struct.
// ----------------------------------------------------------------------------
package crczg_pkg;

    localparam int unsigned REG_W      = 13;   // gap_start / gap_length width
    localparam int unsigned CFG_ADDR_W = 1;
    localparam int unsigned DATA_W     = 8;
    localparam int unsigned CRC_W      = 32;

    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam logic [REG_W-1:0] GAP_START_RST  = 13'd16;
    localparam logic [REG_W-1:0] GAP_LENGTH_RST = 13'd4;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_GAP_START  = 1'b0,
        CFG_GAP_LENGTH = 1'b1
    } cfg_addr_t;

    // one accepted byte towards the core
    typedef struct packed {
        logic en;
        logic last;
    } step_t;

    // eight LSB-first shift/XOR steps, one per message bit
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [DATA_W-1:0] data);
        logic [CRC_W-1:0] v;
        v = crc ^ {{(CRC_W-DATA_W){1'b0}}, data};
        for (int k = 0; k < DATA_W; k++) begin
            if (v[0]) begin
                v = (v >> 1) ^ CRC_POLY;
            end else begin
                v = v >> 1;
            end
        end
        return v;
    endfunction

endpackage

// ----- hdl/crczg_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crczg_core - running CRC and byte position with zero-filled window
// Holds the CRC and saturating byte position; masks bytes inside the window.
// ----------------------------------------------------------------------------
module crczg_core #(
    parameter int unsigned MAX_MESSAGE_BYTES = 4096
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  crczg_pkg::step_t                 step,
    input  logic [crczg_pkg::DATA_W-1:0]     data_byte,
    input  logic [crczg_pkg::REG_W-1:0]      gap_start,
    input  logic [crczg_pkg::REG_W-1:0]      gap_length,
    output logic [crczg_pkg::CRC_W-1:0]      crc_result
);
    import crczg_pkg::*;

    localparam int unsigned POS_W = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam int unsigned END_W = REG_W + 1;
    localparam int unsigned CMP_W = (POS_W > END_W) ? POS_W : END_W;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_MESSAGE_BYTES);

    logic [CRC_W-1:0] crc_reg,  crc_next;
    logic [POS_W-1:0] pos_reg,  pos_next;
    logic [CMP_W-1:0] pos_cmp, start_cmp, end_cmp;
    logic             in_gap;
    logic [CRC_W-1:0] crc_upd;

    // window end computed one bit wider so it never wraps
    assign pos_cmp   = CMP_W'(pos_reg);
    assign start_cmp = CMP_W'(gap_start);
    assign end_cmp   = CMP_W'({1'b0, gap_start} + {1'b0, gap_length});
    assign in_gap    = (pos_cmp >= start_cmp) && (pos_cmp < end_cmp);

    assign crc_upd    = crc_byte(crc_reg, in_gap ? '0 : data_byte);
    assign crc_result = crc_upd ^ CRC_INIT;

    always_comb begin
        crc_next = crc_reg;
        pos_next = pos_reg;
        if (step.en) begin
            if (step.last) begin
                crc_next = CRC_INIT;
                pos_next = '0;
            end else begin
                crc_next = crc_upd;
                if (pos_reg < POS_MAX) begin
                    pos_next = pos_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= CRC_INIT;
            pos_reg <= '0;
        end else begin
            crc_reg <= crc_next;
            pos_reg <= pos_next;
        end
    end

endmodule

// ----- hdl/crc32_with_zero_gap.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc32_with_zero_gap - byte-wide CRC-32 with a zero-filled byte window
// Reflected CRC-32 over a byte stream; bytes in [gap_start, gap_start +
// gap_length) enter as zero. Result on the tlast byte, inverted.
// ----------------------------------------------------------------------------
//  Channel   Dir  Fields (tdata LSB up)          Transfers
//  s_axis    in   data_byte[7:0], tlast=last     one per message byte
//  m_axis    out  crc_result[31:0]               one per message (tlast byte)
//  cfg       in   0: gap_start, 1: gap_length    write only, no back-pressure
//
//  One byte per cycle when not stalled. The CRC update is an 8-step XOR network
//  feeding crc_reg directly, so byte n+1 may follow byte n with no gap.
//  The result is held in an output register; s_axis_tready drops only while
//  that register is full and m_axis_tready is low.
//  Reset (aresetn low, synchronous): CRC all ones, position zero, gap_start 16,
//  gap_length 4, output empty.
// ----------------------------------------------------------------------------
module crc32_with_zero_gap #(
    parameter int unsigned MAX_MESSAGE_BYTES = 4096
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input byte stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [crczg_pkg::DATA_W-1:0]         s_axis_tdata,   // [7:0] data_byte
    input  logic                                 s_axis_tlast,   // last_byte
    // result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [crczg_pkg::CRC_W-1:0]          m_axis_tdata,   // [31:0] crc_result
    // configuration writes
    input  logic                                 cfg_wr_en,
    input  logic [crczg_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [crczg_pkg::REG_W-1:0]          cfg_wdata
);
    import crczg_pkg::*;

    logic [REG_W-1:0]  gap_start_reg,  gap_start_next;
    logic [REG_W-1:0]  gap_length_reg, gap_length_next;
    logic              out_valid_reg,  out_valid_next;
    logic [CRC_W-1:0]  out_data_reg,   out_data_next;
    logic [CRC_W-1:0]  crc_final;
    logic              in_xfer;
    step_t             step;

    // accept while output is empty or being drained this cycle
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    assign step.en   = in_xfer;
    assign step.last = s_axis_tlast;

    crczg_core #(
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .data_byte  (s_axis_tdata),
        .gap_start  (gap_start_reg),
        .gap_length (gap_length_reg),
        .crc_result (crc_final)
    );

    // register decode; writes land from the next byte on
    always_comb begin
        gap_start_next  = gap_start_reg;
        gap_length_next = gap_length_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr_t'(cfg_addr))
                CFG_GAP_START:  gap_start_next  = cfg_wdata;
                CFG_GAP_LENGTH: gap_length_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    // output register: load on the last byte, clear once taken
    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
        if (in_xfer && s_axis_tlast) begin
            out_valid_next = 1'b1;
            out_data_next  = crc_final;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_start_reg  <= GAP_START_RST;
            gap_length_reg <= GAP_LENGTH_RST;
            out_valid_reg  <= 1'b0;
        end else begin
            gap_start_reg  <= gap_start_next;
            gap_length_reg <= gap_length_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
